// ===== rtl/core/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_END,
    ST_APPEND,
    ST_REPORT
  } state_e;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] STAT_RECLAIMED = 3'd0;
  localparam logic [2:0] STAT_APPENDED  = 3'd1;
  localparam logic [2:0] STAT_FREED     = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd5;

  localparam logic CFG_POOL_BASE      = 1'b0;
  localparam logic CFG_RESERVED_BYTES = 1'b1;

  localparam logic [31:0] POOL_BASE_RST      = 32'd2097152;
  localparam logic [31:0] RESERVED_BYTES_RST = 32'd1024;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        used;
  } entry_t;

endpackage

// ===== rtl/core/first_fit_block_allocator_top.sv =====
// First-fit block allocator: block table in RAM walked by a one-entry-per-cycle scan sequencer.
// The scan reads one table entry per cycle through the single RAM read port.
// Throughput: one transaction at a time; busy is high from accept until the result strobe.
// The result is shown for one cycle on valid_o; the receiver cannot stall.
// Reset: table holds only the reserved entry, counters at one, byte count zero; no clearing pass.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [31:0] req_bytes_i,
  input  logic [31:0] free_address_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        valid_o,
  output logic [31:0] address_o,
  output logic [2:0]  status_o,
  output logic [6:0]  blocks_created_o,
  output logic [6:0]  blocks_in_use_o,
  output logic [31:0] bytes_in_use_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = (CW > 7) ? CW : 7;
  localparam logic [CW-1:0] NUM_ENTRIES = CW'(TABLE_ENTRIES);

  state_e state_q, state_d;

  logic [31:0] pool_base_q, reserved_bytes_q;
  logic        func_q;
  logic [31:0] req_q, faddr_q;

  logic [CW-1:0] entry_count_q, entry_count_d;
  logic [CW-1:0] used_count_q, used_count_d;
  logic [31:0]   user_bytes_q, user_bytes_d;

  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic          rdv_q, rdv_d;
  logic [IW-1:0] chk_idx_q, chk_idx_d;
  logic [32:0]   end_q, end_d;

  logic [31:0] res_addr_q, res_addr_d;
  logic [2:0]  res_status_q, res_status_d;

  logic        valid_d;
  logic [31:0] address_d, bytes_in_use_d;
  logic [2:0]  status_d;
  logic [6:0]  blocks_created_d, blocks_in_use_d;

  entry_t        mem_q [TABLE_ENTRIES];
  entry_t        rdata_q;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  logic        hit;
  logic [32:0] add_sum, sub_diff, tot_sum;
  logic [33:0] new_end;
  logic [SW-1:0] ec_ext, uc_ext;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q      <= POOL_BASE_RST;
      reserved_bytes_q <= RESERVED_BYTES_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE:      pool_base_q      <= cfg_wdata_i;
        CFG_RESERVED_BYTES: reserved_bytes_q <= cfg_wdata_i;
        default:            pool_base_q      <= pool_base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q  <= func_i;
      req_q   <= req_bytes_i;
      faddr_q <= free_address_i;
    end
    chk_idx_q        <= chk_idx_d;
    end_q            <= end_d;
    res_addr_q       <= res_addr_d;
    res_status_q     <= res_status_d;
    address_o        <= address_d;
    status_o         <= status_d;
    blocks_created_o <= blocks_created_d;
    blocks_in_use_o  <= blocks_in_use_d;
    bytes_in_use_o   <= bytes_in_use_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      entry_count_q <= CW'(1);
      used_count_q  <= CW'(1);
      user_bytes_q  <= '0;
      scan_idx_q    <= '0;
      rdv_q         <= 1'b0;
      valid_o       <= 1'b0;
    end else begin
      state_q       <= state_d;
      entry_count_q <= entry_count_d;
      used_count_q  <= used_count_d;
      user_bytes_q  <= user_bytes_d;
      scan_idx_q    <= scan_idx_d;
      rdv_q         <= rdv_d;
      valid_o       <= valid_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    if (func_q == FUNC_FREE) begin
      hit = rdv_q && rdata_q.used && (rdata_q.start == faddr_q);
    end else begin
      hit = rdv_q && !rdata_q.used && (rdata_q.size >= req_q);
    end
  end

  assign add_sum  = {1'b0, user_bytes_q} + {1'b0, (state_q == ST_APPEND) ? req_q : rdata_q.size};
  assign sub_diff = {1'b0, user_bytes_q} - {1'b0, rdata_q.size};
  assign tot_sum  = {1'b0, reserved_bytes_q} + {1'b0, user_bytes_q};
  assign new_end  = {1'b0, end_q} + {2'b00, req_q};
  assign ec_ext   = SW'(entry_count_q);
  assign uc_ext   = SW'(used_count_q);

  always_comb begin
    state_d          = state_q;
    entry_count_d    = entry_count_q;
    used_count_d     = used_count_q;
    user_bytes_d     = user_bytes_q;
    scan_idx_d       = scan_idx_q;
    rdv_d            = 1'b0;
    chk_idx_d        = chk_idx_q;
    end_d            = end_q;
    res_addr_d       = res_addr_q;
    res_status_d     = res_status_q;
    valid_d          = 1'b0;
    address_d        = address_o;
    status_d         = status_o;
    blocks_created_d = blocks_created_o;
    blocks_in_use_d  = blocks_in_use_o;
    bytes_in_use_d   = bytes_in_use_o;
    rd_en            = 1'b0;
    rd_addr          = scan_idx_q[IW-1:0];
    wr_en            = 1'b0;
    wr_addr          = chk_idx_q;
    wr_data          = rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          scan_idx_d = CW'(1);
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_d = ST_UPDATE;
        end else if (scan_idx_q < entry_count_q) begin
          rd_en      = 1'b1;
          rdv_d      = 1'b1;
          chk_idx_d  = scan_idx_q[IW-1:0];
          scan_idx_d = scan_idx_q + CW'(1);
        end else if (func_q == FUNC_FREE) begin
          res_addr_d   = '0;
          res_status_d = STAT_NOT_FOUND;
          state_d      = ST_REPORT;
        end else if (entry_count_q >= NUM_ENTRIES) begin
          res_addr_d   = '0;
          res_status_d = STAT_FULL;
          state_d      = ST_REPORT;
        end else begin
          state_d = ST_END;
        end
      end
      ST_UPDATE: begin
        wr_en        = 1'b1;
        wr_data.used = !rdata_q.used;
        if (func_q == FUNC_FREE) begin
          user_bytes_d = sub_diff[32] ? '0 : sub_diff[31:0];
          if (used_count_q > CW'(1)) begin
            used_count_d = used_count_q - CW'(1);
          end
          res_addr_d   = '0;
          res_status_d = STAT_FREED;
        end else begin
          user_bytes_d = add_sum[32] ? '1 : add_sum[31:0];
          if (used_count_q < NUM_ENTRIES) begin
            used_count_d = used_count_q + CW'(1);
          end
          res_addr_d   = rdata_q.start;
          res_status_d = STAT_RECLAIMED;
        end
        state_d = ST_REPORT;
      end
      ST_END: begin
        if (entry_count_q <= CW'(1)) begin
          end_d = {1'b0, pool_base_q} + {1'b0, reserved_bytes_q};
        end else begin
          end_d = {1'b0, rdata_q.start} + {1'b0, rdata_q.size};
        end
        state_d = ST_APPEND;
      end
      ST_APPEND: begin
        if (end_q[32] || (new_end > 34'h1_0000_0000)) begin
          res_addr_d   = '0;
          res_status_d = STAT_OVERFLOW;
        end else begin
          wr_en         = 1'b1;
          wr_addr       = entry_count_q[IW-1:0];
          wr_data.start = end_q[31:0];
          wr_data.size  = req_q;
          wr_data.used  = 1'b1;
          entry_count_d = entry_count_q + CW'(1);
          if (used_count_q < NUM_ENTRIES) begin
            used_count_d = used_count_q + CW'(1);
          end
          user_bytes_d = add_sum[32] ? '1 : add_sum[31:0];
          res_addr_d   = end_q[31:0];
          res_status_d = STAT_APPENDED;
        end
        state_d = ST_REPORT;
      end
      ST_REPORT: begin
        valid_d          = 1'b1;
        address_d        = res_addr_q;
        status_d         = res_status_q;
        blocks_created_d = (ec_ext > SW'(127)) ? 7'd127 : ec_ext[6:0];
        blocks_in_use_d  = (uc_ext > SW'(127)) ? 7'd127 : uc_ext[6:0];
        bytes_in_use_d   = tot_sum[32] ? '1 : tot_sum[31:0];
        state_d          = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
